>>> hdl/ufsef_pkg.sv
// Shared types and constants of the union-find spanning edge filter.
package ufsef_pkg;

    localparam int NODE_W        = 11;
    localparam int WEIGHT_W      = 30;
    localparam int MAX_NODES_DEF = 1024;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1024);

    typedef enum logic [1:0] {
        ST_TAKEN   = 2'd0,
        ST_CYCLE   = 2'd1,
        ST_RANGE   = 2'd2,
        ST_RESTART = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        KIND_EDGE    = 1'b0,
        KIND_RESTART = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [NODE_W-1:0]    node_a;
        logic [NODE_W-1:0]    node_b;
        logic [WEIGHT_W-1:0]  weight;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [NODE_W-1:0]    end_a;
        logic [NODE_W-1:0]    end_b;
        logic [WEIGHT_W-1:0]  edge_weight;
    } t_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_COMP_RD,
        S_COMP_CHK,
        S_JOIN1,
        S_JOIN2,
        S_DONE
    } t_state;

endpackage

>>> hdl/union_find_spanning_edge_filter_unit.sv
// Kruskal edge filter: disjoint-set store with union by size and path compression.
//
// Requests arrive on i_req with i_req_valid / o_req_ready; a request is either an
// edge (two node numbers and a weight) or a restart of all sets. Every request
// gives exactly one response on o_rsp with o_rsp_valid / i_rsp_ready. An edge is
// answered as taken (it joined two sets), as closing a cycle, or as out of range
// when an end node is zero or beyond the node count or store. The user must write the
// node count register via i_cfg_we / i_cfg_data only while the block is idle; the block never checks.
//
// One request is worked on at a time; roots are found by walking parent links in a
// memory with a registered read port. Each end is walked from its node up to its
// root, and if that path is not just the node itself, every node on it is then
// pointed at the root. An edge between two sets writes the link of the root with
// the smaller set (root b on a tie), then the summed size at the other root.
// Out-of-range edges need no memory read; a restart rewrites each entry one per cycle.
//
// After reset the same clearing pass runs, during which no request is accepted. The
// response sits in an output register, so a new request is accepted while an old
// response waits; a finished request waits in its last state until the output
// register is free.
module union_find_spanning_edge_filter_unit
    import ufsef_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [NODE_W-1:0] i_cfg_data,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_req              i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output t_rsp              o_rsp
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int SIZE_W = $clog2(MAX_NODES + 1);
    localparam int ENT_W  = SIZE_W + IDX_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

    // Each memory entry holds the set size (meaningful at roots) above the parent link.
    logic [ENT_W-1:0] r_mem [MAX_NODES];
    logic [ENT_W-1:0] r_rd_data;

    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    t_status          r_status, n_status;
    logic             r_restart, n_restart;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_start, n_start;
    logic             r_side, n_side;
    logic [IDX_W-1:0] r_root_a, n_root_a;
    logic [IDX_W-1:0] r_root_b, n_root_b;
    logic [SIZE_W-1:0] r_size_a, n_size_a;
    logic [SIZE_W-1:0] r_size_b, n_size_b;
    logic [NODE_W-1:0] r_node_count;
    logic              r_out_valid;
    t_rsp              r_out;

    logic              req_fire;
    logic              out_load;
    logic              a_ok;
    logic              b_ok;
    logic [IDX_W-1:0]  in_idx_a;
    logic [IDX_W-1:0]  req_idx_b;
    logic [IDX_W-1:0]  rd_link;
    logic [SIZE_W-1:0] rd_size;
    logic [IDX_W-1:0]  cur_root;
    logic              a_smaller;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_rsp_ready);

    // A node is valid when it lies in 1..node_count and within the store.
    assign a_ok = (i_req.node_a != '0) && (i_req.node_a <= r_node_count)
                  && (32'(i_req.node_a) <= MAX_NODES);
    assign b_ok = (i_req.node_b != '0) && (i_req.node_b <= r_node_count)
                  && (32'(i_req.node_b) <= MAX_NODES);

    // Node n lives in entry n - 1.
    assign in_idx_a  = IDX_W'(i_req.node_a - NODE_W'(1));
    assign req_idx_b = IDX_W'(r_req.node_b - NODE_W'(1));

    assign rd_link   = r_rd_data[IDX_W-1:0];
    assign rd_size   = r_rd_data[ENT_W-1:IDX_W];
    assign cur_root  = r_side ? r_root_b : r_root_a;
    assign a_smaller = (r_size_a < r_size_b);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_IDX) begin
                    n_state = r_restart ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    if (i_req.kind == KIND_RESTART) begin
                        n_state = S_CLEAR;
                    end else if (!a_ok || !b_ok) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (rd_link == r_cur) begin
                    if (r_cur != r_start) begin
                        n_state = S_COMP_RD;
                    end else begin
                        n_state = r_side ? S_JOIN1 : S_WALK_RD;
                    end
                end
            end
            S_COMP_RD: begin
                n_state = S_COMP_CHK;
            end
            S_COMP_CHK: begin
                if (rd_link == cur_root) begin
                    n_state = r_side ? S_JOIN1 : S_WALK_RD;
                end
            end
            S_JOIN1: begin
                n_state = (r_root_a == r_root_b) ? S_DONE : S_JOIN2;
            end
            S_JOIN2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory controls and datapath updates.
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_cur;
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = '0;
        n_req     = r_req;
        n_status  = r_status;
        n_restart = r_restart;
        n_clr     = r_clr;
        n_cur     = r_cur;
        n_start   = r_start;
        n_side    = r_side;
        n_root_a  = r_root_a;
        n_root_b  = r_root_b;
        n_size_a  = r_size_a;
        n_size_b  = r_size_b;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = {SIZE_W'(1), r_clr};
                n_clr     = r_clr + IDX_W'(1);
                n_status  = ST_RESTART;
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_req     = i_req;
                    n_restart = (i_req.kind == KIND_RESTART);
                    n_clr     = '0;
                    n_status  = ST_RANGE;
                    n_cur     = in_idx_a;
                    n_start   = in_idx_a;
                    n_side    = 1'b0;
                end
            end
            S_WALK_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_cur;
            end
            S_WALK_CHK: begin
                if (rd_link == r_cur) begin
                    // Root found: remember it and its size, then compress the path if the walk moved past its start.
                    if (r_side) begin
                        n_root_b = r_cur;
                        n_size_b = rd_size;
                    end else begin
                        n_root_a = r_cur;
                        n_size_a = rd_size;
                    end
                    if (r_cur != r_start) begin
                        n_cur = r_start;
                    end else if (!r_side) begin
                        n_side  = 1'b1;
                        n_cur   = req_idx_b;
                        n_start = req_idx_b;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_link;
                    n_cur     = rd_link;
                end
            end
            S_COMP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_cur;
            end
            S_COMP_CHK: begin
                // Point the visited node at its root, keeping its size field.
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = {rd_size, cur_root};
                if (rd_link == cur_root) begin
                    if (!r_side) begin
                        n_side  = 1'b1;
                        n_cur   = req_idx_b;
                        n_start = req_idx_b;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_link;
                    n_cur     = rd_link;
                end
            end
            S_JOIN1: begin
                if (r_root_a == r_root_b) begin
                    n_status = ST_CYCLE;
                end else begin
                    n_status = ST_TAKEN;
                    mem_we   = 1'b1;
                    if (a_smaller) begin
                        mem_waddr = r_root_a;
                        mem_wdata = {r_size_a, r_root_b};
                    end else begin
                        mem_waddr = r_root_b;
                        mem_wdata = {r_size_b, r_root_a};
                    end
                end
            end
            S_JOIN2: begin
                mem_we    = 1'b1;
                mem_waddr = a_smaller ? r_root_b : r_root_a;
                mem_wdata = {SIZE_W'(r_size_a + r_size_b), mem_waddr};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_restart    <= 1'b0;
            r_node_count <= NODE_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_restart <= n_restart;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_status <= n_status;
        r_cur    <= n_cur;
        r_start  <= n_start;
        r_side   <= n_side;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_size_a <= n_size_a;
        r_size_b <= n_size_b;
        if (out_load) begin
            r_out.status <= r_status;
            if (r_restart) begin
                r_out.end_a       <= '0;
                r_out.end_b       <= '0;
                r_out.edge_weight <= '0;
            end else begin
                r_out.end_a       <= r_req.node_a;
                r_out.end_b       <= r_req.node_b;
                r_out.edge_weight <= r_req.weight;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
